### design/pps_sup_pkg.sv
// Types and constants shared by the PPS supervisor design files.
// Depends on nothing; compile first.
package pps_sup_pkg;

   localparam int unsigned NS_W     = 30;
   localparam int unsigned SEC_W    = 32;
   localparam int unsigned PPS_W    = 62;
   localparam int unsigned CAP_W    = 63;
   localparam int unsigned CNT_W    = 17;
   localparam int unsigned LIMIT_W  = 16;
   localparam int unsigned THR_W    = 8;
   localparam int unsigned DELAY_W  = 20;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [1:0] CMD_SYNC     = 2'd0;
   localparam logic [1:0] CMD_ANNOUNCE = 2'd1;
   localparam logic [1:0] CMD_PPS      = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NO_PPS_LIMIT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK_THRESHOLD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_DELAY_NS = 2'd2;

   localparam logic [LIMIT_W-1:0] NO_PPS_LIMIT_RST     = 16'd40;
   localparam logic [THR_W-1:0]   LOCK_THRESHOLD_RST   = 8'd5;
   localparam logic [DELAY_W-1:0] COMPARE_DELAY_NS_RST = 20'd60;

   localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
   localparam logic [31:0] TWO_SEC_NS   = 32'd2000000000;
   localparam logic [NS_W-1:0] LOW_WRAP_NS  = 30'd100000000;
   localparam logic [NS_W-1:0] HIGH_WRAP_NS = 30'd900000000;
   localparam logic [NS_W-1:0] HALF_SEC_NS  = 30'd500000000;

   localparam logic [7:0] CLASS_LOCKED  = 8'd13;
   localparam logic [7:0] CLASS_FREE    = 8'd248;
   localparam logic [7:0] SOURCE_LOCKED = 8'h90;
   localparam logic [7:0] SOURCE_FREE   = 8'ha0;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [NS_W-1:0]  capture_raw_ns;
      logic [SEC_W-1:0] timer_sec;
      logic [NS_W-1:0]  timer_ns;
      logic [7:0]       servo_lock_count;
   } req_payload_type;

   typedef struct packed {
      logic                    sync_request;
      logic                    pps_valid;
      logic [PPS_W-1:0]        pps_time_ns;
      logic signed [CAP_W-1:0] capture_time_ns;
      logic                    locked;
      logic                    announce_now;
      logic [7:0]              clock_class;
      logic [7:0]              time_source;
   } rsp_payload_type;

   // per-beat flags decided at accept time
   typedef struct packed {
      logic is_pps;
      logic announce;
      logic sync_req;
      logic locked;
   } flags_type;

endpackage

### design/pps_sup_chan_if.sv
// Valid/ready channel carrying one payload struct per beat.
// Payload type comes from pps_sup_pkg at instantiation.
interface pps_sup_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### design/pps_timestamp_and_loss_supervisor.sv
// PPS timestamp and loss supervisor top level: three-stage beat pipeline.
// Depends on pps_sup_pkg and pps_sup_chan_if.
//
//   channel    dir  handshake          payload
//   req_chan   in   valid/ready        req_payload_type (cmd, capture, timer, lock count)
//   rsp_chan   out  valid/ready        rsp_payload_type (timestamps, lock status)
//   csr_*      in   csr_we only        index 0..2, data 20 bits
//
// One beat per cycle unless rsp_chan stalls; each beat passes s1, s2 and out registers.
// Stages: input register, multiply by 1e9 plus modulo reduction, final add.
// The loss counter updates at accept, so back-to-back beats see each other's effect.
// Each stage holds while the next is full and stalled; bubbles collapse.
// Reset (synchronous) empties the pipe, clears the counter and loads register defaults.
module pps_timestamp_and_loss_supervisor
   import pps_sup_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pps_sup_chan_if.sink          req_chan,
   pps_sup_chan_if.source        rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] no_pps_limit_ff;
   logic [THR_W-1:0]   lock_threshold_ff;
   logic [DELAY_W-1:0] compare_delay_ns_ff;
   logic [CNT_W-1:0]   ticks_ff, ticks_in;

   logic s1_v_ff, s2_v_ff, out_v_ff;
   logic s1_free, s2_free, out_free;
   logic req_acc;

   // stage 1
   flags_type          s1_flags_ff, s1_flags_in;
   logic [NS_W-1:0]    s1_raw_ff;
   logic [DELAY_W-1:0] s1_delay_ff;
   logic [SEC_W-1:0]   s1_tsec_ff;
   logic [NS_W-1:0]    s1_tns_ff;

   // stage 2
   flags_type          s2_flags_ff;
   logic [PPS_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [NS_W-1:0]    s2_t_ff, s2_t_in;
   logic               s2_low_ff, s2_half_ff;
   logic [31:0]        s1_sum;

   // output
   rsp_payload_type    out_ff, out_in;
   logic               wrap;
   logic [31:0]        cap_off;
   logic [CAP_W-1:0]   cap_sum;

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign s2_free  = !s2_v_ff || out_free;
   assign s1_free  = !s1_v_ff || s2_free;
   assign req_chan.ready = s1_free;
   assign req_acc  = req_chan.valid && s1_free;

   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.data  = out_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         no_pps_limit_ff     <= NO_PPS_LIMIT_RST;
         lock_threshold_ff   <= LOCK_THRESHOLD_RST;
         compare_delay_ns_ff <= COMPARE_DELAY_NS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NO_PPS_LIMIT:     no_pps_limit_ff     <= csr_wdata[LIMIT_W-1:0];
            CSR_LOCK_THRESHOLD:   lock_threshold_ff   <= csr_wdata[THR_W-1:0];
            CSR_COMPARE_DELAY_NS: compare_delay_ns_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // accept: loss counter and status flags
   always_comb begin
      ticks_in    = ticks_ff;
      s1_flags_in = '0;
      case (req_chan.data.cmd)
         CMD_SYNC: begin
            if (ticks_ff > {1'b0, no_pps_limit_ff}) begin
               s1_flags_in.sync_req = 1'b1;
            end else begin
               ticks_in = ticks_ff + 1'b1;
            end
         end
         CMD_ANNOUNCE: begin
            s1_flags_in.announce = 1'b1;
         end
         CMD_PPS: begin
            ticks_in             = '0;
            s1_flags_in.is_pps   = 1'b1;
            s1_flags_in.sync_req = req_chan.data.servo_lock_count > lock_threshold_ff;
         end
         default: ;
      endcase
      s1_flags_in.locked = (req_chan.data.servo_lock_count > lock_threshold_ff)
                           && (ticks_in < {1'b0, no_pps_limit_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= '0;
      end else if (req_acc) begin
         ticks_ff <= ticks_in;
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_free) begin
         s1_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_flags_ff <= s1_flags_in;
         s1_raw_ff   <= req_chan.data.capture_raw_ns;
         s1_delay_ff <= compare_delay_ns_ff;
         s1_tsec_ff  <= req_chan.data.timer_sec;
         s1_tns_ff   <= req_chan.data.timer_ns;
      end
   end

   // stage 2: seconds to ns, corrected ns modulo one second
   always_comb begin
      s2_prod_in = {30'd0, s1_tsec_ff} * {30'd0, NS_PER_SEC};
      s1_sum     = {2'b00, s1_raw_ff} + NS_PER_SEC - {12'd0, s1_delay_ff};
      if (s1_sum >= TWO_SEC_NS) begin
         s2_t_in = NS_W'(s1_sum - TWO_SEC_NS);
      end else if (s1_sum >= NS_PER_SEC) begin
         s2_t_in = NS_W'(s1_sum - NS_PER_SEC);
      end else begin
         s2_t_in = NS_W'(s1_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_free) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_v_ff) begin
         s2_flags_ff <= s1_flags_ff;
         s2_prod_ff  <= s2_prod_in;
         s2_t_ff     <= s2_t_in;
         s2_low_ff   <= s1_tns_ff < LOW_WRAP_NS;
         s2_half_ff  <= s1_tns_ff < HALF_SEC_NS;
      end
   end

   // output stage: second assignment and final add
   always_comb begin
      wrap    = s2_low_ff && (s2_t_ff > HIGH_WRAP_NS);
      cap_off = {2'b00, s2_t_ff} - (wrap ? NS_PER_SEC : 32'd0);
      cap_sum = {1'b0, s2_prod_ff} + {{(CAP_W-32){cap_off[31]}}, cap_off};

      out_in                 = '0;
      out_in.sync_request    = s2_flags_ff.sync_req;
      out_in.announce_now    = s2_flags_ff.announce;
      out_in.locked          = s2_flags_ff.locked;
      out_in.clock_class     = s2_flags_ff.locked ? CLASS_LOCKED : CLASS_FREE;
      out_in.time_source     = s2_flags_ff.locked ? SOURCE_LOCKED : SOURCE_FREE;
      if (s2_flags_ff.is_pps) begin
         out_in.pps_valid       = 1'b1;
         out_in.pps_time_ns     = s2_prod_ff +
                                  ((!wrap && !s2_half_ff) ? {30'd0, NS_PER_SEC} : '0);
         out_in.capture_time_ns = cap_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_v_ff) begin
         out_ff <= out_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_pps_clears_count: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_chan.data.cmd == CMD_PPS) |=> ticks_ff == '0)
      else $error("loss counter not cleared by PPS beat");

   a_sync_counts: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_chan.data.cmd == CMD_SYNC) && (ticks_ff <= {1'b0, no_pps_limit_ff})
      |=> ticks_ff == $past(ticks_ff) + 1'b1)
      else $error("sync beat did not advance loss counter");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_v_ff && s2_v_ff && out_v_ff && !rsp_chan.ready)
      else $error("input stalled with room in the pipe");

   a_nonpps_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.data.pps_valid
      |-> rsp_chan.data.pps_time_ns == '0 && rsp_chan.data.capture_time_ns == '0)
      else $error("timestamps set on non-PPS beat");
`endif

endmodule
